@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pld_pkg.sv @@
// package with sizes, codes and control types of the pooled list deque
package pld_pkg;

    localparam int POOL_ENTRIES = 64;
    localparam int HANDLE_BITS  = 32;

    localparam int OP_W        = 2;
    localparam int HANDLE_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    localparam int IDX_W    = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int LINK_W   = IDX_W + 1;
    localparam int COUNT_W  = $clog2(POOL_ENTRIES + 1);
    localparam int HSTORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    localparam logic [LINK_W-1:0] NIL_LINK = '1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_NOP        = 3'd0,
        CMD_START      = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_PUSH_BACK  = 3'd3,
        CMD_PUSH_TAIL  = 3'd4,
        CMD_WALK       = 3'd5,
        CMD_POP        = 3'd6
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t op;
        logic    emit;
        status_t status;
    } pld_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic full;
        logic tail_valid;
        logic walk_hit;
        logic next_valid;
        logic op_front;
        logic out_free;
    } pld_sts_t;

endpackage

@@ hw/rtl/pld_if.sv @@
// request and response channel interfaces of the pooled list deque
interface pld_req_if;
    logic                          valid;
    logic                          ready;
    logic [pld_pkg::OP_W-1:0]      operation;
    logic [pld_pkg::HANDLE_W-1:0]  handle;

    modport source (output valid, output operation, output handle, input ready);
    modport sink   (input valid, input operation, input handle, output ready);
endinterface

interface pld_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [pld_pkg::HANDLE_W-1:0]    popped_handle;
    logic [pld_pkg::STATUS_W-1:0]    status;
    logic [pld_pkg::COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, output popped_handle, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input popped_handle, input status, input entry_count,
                    output ready);
endinterface

@@ hw/rtl/pld_dpath.sv @@
// datapath: link and handle stores, list pointers, count and result register
module pld_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pld_pkg::pld_cmd_t                 cmd,
    output pld_pkg::pld_sts_t                 sts,
    input  logic [pld_pkg::OP_W-1:0]          in_operation,
    input  logic [pld_pkg::HANDLE_W-1:0]      in_handle,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pld_pkg::HANDLE_W-1:0]      out_popped,
    output logic [pld_pkg::STATUS_W-1:0]      out_status,
    output logic [pld_pkg::COUNT_OUT_W-1:0]   out_count
);

    localparam int N   = pld_pkg::POOL_ENTRIES;
    localparam int IW  = pld_pkg::IDX_W;
    localparam int LW  = pld_pkg::LINK_W;
    localparam int CW  = pld_pkg::COUNT_W;
    localparam int HW  = pld_pkg::HSTORE_W;

    function automatic logic link_ok(input logic [LW-1:0] l);
        return l < LW'(N);
    endfunction

    function automatic logic [LW-1:0] reset_link(input logic [IW-1:0] a);
        logic [LW-1:0] r;
        if (a == IW'(N - 1))
            r = pld_pkg::NIL_LINK;
        else
            r = LW'(a) + LW'(1);
        return r;
    endfunction

    logic [LW-1:0] link_mem_reg [N];
    logic [HW-1:0] handle_mem_reg [N];

    logic [N-1:0]  link_valid_reg, link_valid_next;
    logic [LW-1:0] link_rdata_reg;
    logic          link_rd_valid_reg;
    logic [IW-1:0] link_rd_addr_reg;
    logic [HW-1:0] hdl_rdata_reg;

    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] tail_reg, tail_next;
    logic [LW-1:0] free_reg, free_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [HW-1:0] handle_reg, handle_next;
    logic          op_front_reg, op_front_next;

    logic                            out_valid_reg, out_valid_next;
    logic [pld_pkg::HANDLE_W-1:0]    out_popped_reg, out_popped_next;
    logic [pld_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [pld_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic          link_rd_en, link_wr_en, hdl_rd_en, hdl_wr_en;
    logic [IW-1:0] link_rd_addr, link_wr_addr, hdl_rd_addr, hdl_wr_addr;
    logic [LW-1:0] link_wr_data;

    logic [LW-1:0] link_word;
    logic          out_free;

    // entries never written read as their reset link
    assign link_word = link_rd_valid_reg ? link_rdata_reg : reset_link(link_rd_addr_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign sts.count_zero = (count_reg == '0);
    assign sts.count_one  = (count_reg == CW'(1));
    assign sts.full       = (count_reg >= CW'(N)) || !link_ok(free_reg);
    assign sts.tail_valid = link_ok(tail_reg);
    assign sts.walk_hit   = (link_word == LW'(slot_reg));
    assign sts.next_valid = link_ok(link_word);
    assign sts.op_front   = op_front_reg;
    assign sts.out_free   = out_free;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_next       = free_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        handle_next     = handle_reg;
        op_front_next   = op_front_reg;
        link_rd_en      = 1'b0;
        link_rd_addr    = cur_reg;
        link_wr_en      = 1'b0;
        link_wr_addr    = free_reg[IW-1:0];
        link_wr_data    = pld_pkg::NIL_LINK;
        hdl_rd_en       = 1'b0;
        hdl_rd_addr     = tail_reg[IW-1:0];
        hdl_wr_en       = 1'b0;
        hdl_wr_addr     = free_reg[IW-1:0];

        case (cmd.op)
            pld_pkg::CMD_START:
            begin
                op_front_next = (in_operation == pld_pkg::OP_PUSH_FRONT);
                handle_next   = in_handle[HW-1:0];
                slot_next     = tail_reg[IW-1:0];
                cur_next      = head_reg[IW-1:0];
                link_rd_en    = 1'b1;
                link_rd_addr  = (in_operation == pld_pkg::OP_POP_BACK) ? head_reg[IW-1:0]
                                                                       : free_reg[IW-1:0];
                hdl_rd_en     = 1'b1;
            end
            pld_pkg::CMD_PUSH_FRONT:
            begin
                link_wr_en   = 1'b1;
                link_wr_data = head_reg;
                hdl_wr_en    = 1'b1;
                free_next    = link_word;
                head_next    = free_reg;
                if (sts.count_zero)
                    tail_next = free_reg;
                count_next   = count_reg + CW'(1);
            end
            pld_pkg::CMD_PUSH_BACK:
            begin
                link_wr_en   = 1'b1;
                hdl_wr_en    = 1'b1;
                free_next    = link_word;
                if (sts.count_zero)
                    head_next = free_reg;
                cur_next     = tail_reg[IW-1:0];
                tail_next    = free_reg;
                count_next   = count_reg + CW'(1);
            end
            pld_pkg::CMD_PUSH_TAIL:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = cur_reg;
                link_wr_data = tail_reg;
            end
            pld_pkg::CMD_WALK:
            begin
                if (sts.walk_hit)
                begin
                    tail_next    = LW'(cur_reg);
                    link_wr_en   = 1'b1;
                    link_wr_addr = cur_reg;
                end
                else if (!sts.next_valid)
                begin
                    tail_next = link_word;
                end
                else
                begin
                    cur_next     = link_word[IW-1:0];
                    link_rd_en   = 1'b1;
                    link_rd_addr = link_word[IW-1:0];
                end
            end
            pld_pkg::CMD_POP:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = slot_reg;
                link_wr_data = free_reg;
                free_next    = LW'(slot_reg);
                count_next   = count_reg - CW'(1);
                if (sts.count_one)
                begin
                    head_next = pld_pkg::NIL_LINK;
                    tail_next = pld_pkg::NIL_LINK;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        link_valid_next = link_valid_reg;
        if (link_wr_en)
            link_valid_next[link_wr_addr] = 1'b1;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_popped_next = out_popped_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_popped_next = (cmd.op == pld_pkg::CMD_POP) ? pld_pkg::HANDLE_W'(hdl_rdata_reg)
                                                           : '0;
            out_status_next = cmd.status;
            out_count_next  = pld_pkg::COUNT_OUT_W'(count_next);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= pld_pkg::NIL_LINK;
            tail_reg       <= pld_pkg::NIL_LINK;
            free_reg       <= '0;
            count_reg      <= '0;
            link_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_reg       <= free_next;
            count_reg      <= count_next;
            link_valid_reg <= link_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        slot_reg       <= slot_next;
        handle_reg     <= handle_next;
        op_front_reg   <= op_front_next;
        out_popped_reg <= out_popped_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // link store, registered read
    always_ff @(posedge clk)
    begin
        if (link_wr_en)
            link_mem_reg[link_wr_addr] <= link_wr_data;
        if (link_rd_en)
        begin
            link_rdata_reg    <= link_mem_reg[link_rd_addr];
            link_rd_valid_reg <= link_valid_reg[link_rd_addr];
            link_rd_addr_reg  <= link_rd_addr;
        end
    end

    // handle store, registered read
    always_ff @(posedge clk)
    begin
        if (hdl_wr_en)
            handle_mem_reg[hdl_wr_addr] <= handle_reg;
        if (hdl_rd_en)
            hdl_rdata_reg <= handle_mem_reg[hdl_rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign out_popped = out_popped_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

@@ hw/rtl/pld_ctrl.sv @@
// controller state machine sequencing push, walk and pop steps
module pld_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [pld_pkg::OP_W-1:0]     in_operation,
    output logic                         in_ready,
    input  pld_pkg::pld_sts_t            sts,
    output pld_pkg::pld_cmd_t            cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_PUSH_TAIL,
        S_WALK,
        S_POP,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    pld_pkg::status_t  fin_status_reg, fin_status_next;

    logic is_push;
    logic is_pop;

    assign is_push = (in_operation == pld_pkg::OP_PUSH_FRONT) ||
                     (in_operation == pld_pkg::OP_PUSH_BACK);
    assign is_pop  = (in_operation == pld_pkg::OP_POP_BACK);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        fin_status_next = fin_status_reg;
        cmd             = '{op: pld_pkg::CMD_NOP, emit: 1'b0, status: pld_pkg::ST_DONE};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = pld_pkg::CMD_START;
                    if (is_push && sts.full)
                    begin
                        fin_status_next = pld_pkg::ST_FULL;
                        state_next      = S_FIN;
                    end
                    else if (is_push)
                    begin
                        state_next = S_PUSH;
                    end
                    else if (is_pop && (sts.count_zero || !sts.tail_valid))
                    begin
                        fin_status_next = pld_pkg::ST_EMPTY;
                        state_next      = S_FIN;
                    end
                    else if (is_pop && sts.count_one)
                    begin
                        state_next = S_POP;
                    end
                    else if (is_pop)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        fin_status_next = pld_pkg::ST_DONE;
                        state_next      = S_FIN;
                    end
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    if (sts.op_front)
                    begin
                        cmd.op     = pld_pkg::CMD_PUSH_FRONT;
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.op = pld_pkg::CMD_PUSH_BACK;
                        if (sts.count_zero || !sts.tail_valid)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_PUSH_TAIL;
                        end
                    end
                end
            end
            S_PUSH_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = pld_pkg::CMD_PUSH_TAIL;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                cmd.op = pld_pkg::CMD_WALK;
                if (sts.walk_hit || !sts.next_valid)
                    state_next = S_POP;
            end
            S_POP:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = pld_pkg::CMD_POP;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = fin_status_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fin_status_reg <= pld_pkg::ST_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            fin_status_reg <= fin_status_next;
        end
    end

endmodule

@@ hw/rtl/pooled_linked_list_deque.sv @@
// top level of the pooled linked list deque
// A singly linked list of data handles kept in a pool of 64 entries with its own free
// list. Each request word pushes a handle at the front, pushes one at the back or pops
// the back entry, and gives exactly one response word with the popped handle, a status
// and the entry count afterwards. One request is worked at a time; the link store has a
// single registered read port and one write port, and that sets the timing. A push at
// the front reads the free entry's link and writes the new entry; a push at the back
// also writes the old tail's link, in a step of its own, unless the list was empty. A
// pop walks from the head to the entry before the tail, reading one link per cycle; a
// one-entry list needs no walk. The response sits in an output register, so the next
// request is taken while a response waits; a request that finishes while the earlier
// response is still held waits for it to be taken. After reset the block is ready at
// once: link entries not yet written read as their reset chain, so there is no
// clearing pass.
`include "assert_macros.svh"

module pooled_linked_list_deque (
    input  logic       clk,
    input  logic       rst_n,
    pld_req_if.sink    req,
    pld_rsp_if.source  rsp
);

    pld_pkg::pld_cmd_t cmd;
    pld_pkg::pld_sts_t sts;

    pld_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_operation (req.operation),
        .in_ready     (req.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    pld_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_operation (req.operation),
        .in_handle    (req.handle),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_popped   (rsp.popped_handle),
        .out_status   (rsp.status),
        .out_count    (rsp.entry_count)
    );

    // a response is only loaded when the output register can take it
    `PLD_ASSERT_IMP(a_emit_slot_free, clk, rst_n, cmd.emit, sts.out_free, "response overwritten")

    // one request word at a time
    `PLD_ASSERT_NXT(a_one_word, clk, rst_n, req.valid && req.ready, !req.ready, "second word taken")

    // failed operations return no handle
    `PLD_ASSERT_IMP(a_fail_zero, clk, rst_n, rsp.valid && (rsp.status != pld_pkg::ST_DONE), rsp.popped_handle == '0, "handle on failure")

    // a walk never starts with fewer than two entries
    `PLD_ASSERT_IMP(a_walk_count, clk, rst_n, cmd.op == pld_pkg::CMD_WALK, !sts.count_zero && !sts.count_one, "walk on short list")

endmodule
